// ----- hw/rtl/lltqd_pkg.sv -----
// lltqd_pkg: shared types and constants for the least-loaded two-queue dispatcher
// no dependencies; used by lltqd_ctrl, lltqd_dp and the top level
package lltqd_pkg;

  // command codes carried in the input word
  localparam logic [1:0] CMD_SUBMIT   = 2'd0;
  localparam logic [1:0] CMD_POP_ZERO = 2'd1;
  localparam logic [1:0] CMD_POP_ONE  = 2'd2;

  // field widths
  localparam int unsigned IdW    = 16;
  localparam int unsigned DurW   = 6;
  localparam int unsigned TotalW = 10;
  localparam int unsigned CountW = 16;

  // duration limit after reset
  localparam logic [TotalW-1:0] LIMIT_RESET = 10'd45;

  // input word
  typedef struct packed {
    logic [1:0]      cmd;
    logic [DurW-1:0] task_duration;
  } in_word_t;

  // result word
  typedef struct packed {
    logic              accepted;
    logic              chosen_queue;
    logic [IdW-1:0]    assigned_id;
    logic              pop_valid;
    logic [IdW-1:0]    popped_id;
    logic [DurW-1:0]   popped_duration;
    logic [TotalW-1:0] total_zero;
    logic [TotalW-1:0] total_one;
    logic [CountW-1:0] rejected_count;
    logic [CountW-1:0] completed_count;
  } out_word_t;

  // one queued task as held in a queue store
  typedef struct packed {
    logic [IdW-1:0]  id;
    logic [DurW-1:0] duration;
  } entry_t;

  // controller commands to the datapath
  typedef struct packed {
    logic capture;
    logic execute;
  } ctrl_t;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_OUT  = 3'b100
  } state_e;

endpackage

// ----- hw/rtl/lltqd_ctrl.sv -----
// lltqd_ctrl: handshake sequencer for the dispatcher
// depends on lltqd_pkg; drives capture and execute commands to lltqd_dp
module lltqd_ctrl import lltqd_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output ctrl_t ctrl_o
);

  state_e state_q, state_d;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_ready_i) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // handshakes and datapath commands
  assign in_ready_o     = (state_q == S_IDLE);
  assign out_valid_o    = (state_q == S_OUT);
  assign ctrl_o.capture = (state_q == S_IDLE) && in_valid_i;
  assign ctrl_o.execute = (state_q == S_EXEC);

endmodule

// ----- hw/rtl/lltqd_dp.sv -----
// lltqd_dp: queue stores, pointers, totals, counters and result register
// depends on lltqd_pkg; sequenced by lltqd_ctrl
module lltqd_dp import lltqd_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ctrl_t             ctrl_i,
  input  in_word_t          in_word_i,
  input  logic              cfg_we_i,
  input  logic [TotalW-1:0] cfg_data_i,
  output out_word_t         res_o
);

  localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  // stores
  entry_t mem0_q [QUEUE_DEPTH];
  entry_t mem1_q [QUEUE_DEPTH];
  entry_t rd0_q, rd1_q;

  // captured word
  logic [1:0]      cmd_q;
  logic [DurW-1:0] dur_q;

  // control state
  logic [AW-1:0]     head_q  [2];
  logic [AW-1:0]     head_d  [2];
  logic [CW-1:0]     cnt_q   [2];
  logic [CW-1:0]     cnt_d   [2];
  logic [TotalW-1:0] total_q [2];
  logic [TotalW-1:0] total_d [2];
  logic [IdW-1:0]    next_id_q, next_id_d;
  logic [CountW-1:0] rej_q, rej_d;
  logic [CountW-1:0] done_q, done_d;
  logic [TotalW-1:0] limit_q;
  out_word_t         res_q, res_d;

  // derived pointers
  logic [AW-1:0] tail     [2];
  logic [AW-1:0] head_inc [2];
  logic          full     [2];
  logic [CW:0]   tail_sum [2];

  // submit decision
  logic              sel_one;
  logic [TotalW-1:0] sel_total;
  logic              sel_full;
  logic [TotalW:0]   new_sum;
  logic              fits;
  logic              wr0, wr1;

  // pop operands
  logic              pop_one;
  logic [CW-1:0]     pop_cnt;
  logic [TotalW-1:0] pop_total;
  entry_t            pop_entry;

  // tail slot, head advance and full flag per queue
  always_comb begin
    for (int q = 0; q < 2; q++) begin
      tail_sum[q] = (CW+1)'(head_q[q]) + (CW+1)'(cnt_q[q]);
      if (tail_sum[q] >= (CW+1)'(QUEUE_DEPTH)) begin
        tail_sum[q] = tail_sum[q] - (CW+1)'(QUEUE_DEPTH);
      end
      tail[q]     = tail_sum[q][AW-1:0];
      head_inc[q] = (head_q[q] == AW'(QUEUE_DEPTH - 1)) ? '0 : head_q[q] + AW'(1);
      full[q]     = (cnt_q[q] == CW'(QUEUE_DEPTH));
    end
  end

  // least-loaded pick, ties to queue zero, then limit and full check
  assign sel_one   = (total_q[0] > total_q[1]);
  assign sel_total = sel_one ? total_q[1] : total_q[0];
  assign sel_full  = sel_one ? full[1] : full[0];
  assign new_sum   = {1'b0, sel_total} + (TotalW+1)'(dur_q);
  assign fits      = (new_sum <= {1'b0, limit_q}) && !sel_full;
  assign wr0       = ctrl_i.execute && (cmd_q == CMD_SUBMIT) && fits && !sel_one;
  assign wr1       = ctrl_i.execute && (cmd_q == CMD_SUBMIT) && fits && sel_one;

  // pop operands
  assign pop_one   = (cmd_q == CMD_POP_ONE);
  assign pop_cnt   = pop_one ? cnt_q[1] : cnt_q[0];
  assign pop_total = pop_one ? total_q[1] : total_q[0];
  assign pop_entry = pop_one ? rd1_q : rd0_q;

  // step update
  always_comb begin
    head_d    = head_q;
    cnt_d     = cnt_q;
    total_d   = total_q;
    next_id_d = next_id_q;
    rej_d     = rej_q;
    done_d    = done_q;
    res_d     = res_q;
    if (ctrl_i.execute) begin
      res_d = '0;
      case (cmd_q)
        CMD_SUBMIT: begin
          res_d.chosen_queue = sel_one;
          res_d.assigned_id  = next_id_q;
          next_id_d          = next_id_q + IdW'(1);
          if (fits) begin
            res_d.accepted = 1'b1;
            if (sel_one) begin
              cnt_d[1]   = cnt_q[1] + CW'(1);
              total_d[1] = new_sum[TotalW-1:0];
            end else begin
              cnt_d[0]   = cnt_q[0] + CW'(1);
              total_d[0] = new_sum[TotalW-1:0];
            end
          end else if (rej_q != '1) begin
            rej_d = rej_q + CountW'(1);
          end
        end
        CMD_POP_ZERO, CMD_POP_ONE: begin
          if (pop_cnt != '0) begin
            res_d.pop_valid       = 1'b1;
            res_d.popped_id       = pop_entry.id;
            res_d.popped_duration = pop_entry.duration;
            if (done_q != '1) done_d = done_q + CountW'(1);
            if (pop_one) begin
              head_d[1]  = head_inc[1];
              cnt_d[1]   = cnt_q[1] - CW'(1);
              total_d[1] = (pop_total >= TotalW'(pop_entry.duration)) ?
                           pop_total - TotalW'(pop_entry.duration) : '0;
            end else begin
              head_d[0]  = head_inc[0];
              cnt_d[0]   = cnt_q[0] - CW'(1);
              total_d[0] = (pop_total >= TotalW'(pop_entry.duration)) ?
                           pop_total - TotalW'(pop_entry.duration) : '0;
            end
          end
        end
        default: begin
        end
      endcase
      res_d.total_zero      = total_d[0];
      res_d.total_one       = total_d[1];
      res_d.rejected_count  = rej_d;
      res_d.completed_count = done_d;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int q = 0; q < 2; q++) begin
        head_q[q]  <= '0;
        cnt_q[q]   <= '0;
        total_q[q] <= '0;
      end
      next_id_q <= '0;
      rej_q     <= '0;
      done_q    <= '0;
      limit_q   <= LIMIT_RESET;
    end else begin
      head_q    <= head_d;
      cnt_q     <= cnt_d;
      total_q   <= total_d;
      next_id_q <= next_id_d;
      rej_q     <= rej_d;
      done_q    <= done_d;
      if (cfg_we_i) limit_q <= cfg_data_i;
    end
  end

  // captured word and result register
  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      cmd_q <= in_word_i.cmd;
      dur_q <= in_word_i.task_duration;
    end
    res_q <= res_d;
  end

  // queue stores: head read on capture, tail write on execute
  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      rd0_q <= mem0_q[head_q[0]];
      rd1_q <= mem1_q[head_q[1]];
    end
    if (wr0) mem0_q[tail[0]] <= '{id: next_id_q, duration: dur_q};
    if (wr1) mem1_q[tail[1]] <= '{id: next_id_q, duration: dur_q};
  end

  assign res_o = res_q;

endmodule

// ----- hw/rtl/least_loaded_two_queue_dispatcher.sv -----
// least_loaded_two_queue_dispatcher: top level joining controller and datapath
// depends on lltqd_pkg, lltqd_ctrl and lltqd_dp
//
// Each accepted word is first captured while the heads of both queue stores
// are read, then the decision is made and the queues, totals and counters are
// updated, and then the result is presented until it is taken. The next word
// is taken once the result has left, so no new word is taken while one is in
// flight. The duration limit register may be written at any cycle; its ready
// is always high.
module least_loaded_two_queue_dispatcher import lltqd_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  in_word_t          in_word_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output out_word_t         out_word_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [TotalW-1:0] cfg_data_i
);

  ctrl_t ctrl;

  // sequencer
  lltqd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .ctrl_o      (ctrl)
  );

  // queues and result
  lltqd_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .in_word_i  (in_word_i),
    .cfg_we_i   (cfg_valid_i),
    .cfg_data_i (cfg_data_i),
    .res_o      (out_word_o)
  );

  assign cfg_ready_o = 1'b1;

  // one word in flight at a time
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("input ready while a result is pending");

  // an accepted word is executed in the next cycle
  a_capture_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> ctrl.execute)
    else $error("accepted word not executed");

  // execution is followed by a presented result
  a_exec_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.execute |=> out_valid_o)
    else $error("result not presented after execution");

  // a result is either a submit or a pop, never both
  a_kind_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_word_o.accepted && out_word_o.pop_valid))
    else $error("submit and pop flags both set");

endmodule
